### rtl/lav_pkg.sv
// Shared types, constants and helper functions for the look-at view matrix block.
package lav_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW = FRAC_BITS + 2;
    localparam int ITW = 5;
    localparam int QDEPTH = 2;
    localparam int QPW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);
    localparam logic [31:0] ONE_FIX = 32'(64'd1 << FRAC_BITS);

    typedef logic signed [31:0] fix_t;
    typedef logic signed [32:0] vec_t;
    typedef logic signed [63:0] acc_t;
    typedef fix_t [2:0] eye_t;

    typedef enum logic [1:0] {
        CFG_EYE_X = 2'd0,
        CFG_EYE_Y = 2'd1,
        CFG_EYE_Z = 2'd2
    } cfg_index_t;

    typedef struct packed {
        fix_t target_x;
        fix_t target_y;
        fix_t target_z;
        fix_t up_x;
        fix_t up_y;
        fix_t up_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0] row_index;
        fix_t       elem0;
        fix_t       elem1;
        fix_t       elem2;
        fix_t       elem3;
        logic       degenerate;
        logic       last;
    } out_item_t;

    typedef struct packed {
        vec_t [2:0] d;
        fix_t [2:0] up;
    } job_t;

    typedef struct packed {
        logic       start;
        acc_t [2:0] vec;
    } norm_req_t;

    typedef struct packed {
        logic       done;
        logic       ok;
        vec_t [2:0] u;
    } norm_rsp_t;

    function automatic logic [63:0] mag64(input acc_t v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic acc_t shift_round(input acc_t p);
        logic [64:0] mag;
        logic [64:0] m;
        mag = p[63] ? (65'd0 - {p[63], p}) : {1'b0, p};
        m = (mag + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return p[63] ? -acc_t'(m[63:0]) : acc_t'(m[63:0]);
    endfunction

    function automatic fix_t sat32(input acc_t v);
        if (v > acc_t'(64'sd2147483647))
            return fix_t'(32'h7fffffff);
        else if (v < acc_t'(-64'sd2147483648))
            return fix_t'(32'h80000000);
        else
            return fix_t'(v[31:0]);
    endfunction

    function automatic logic [1:0] next3(input logic [1:0] k);
        return (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

endpackage

### rtl/lav_front.sv
// Front end: eye registers, configuration port and input acceptance into the job queue.
module lav_front import lav_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  fix_t       cfg_data,
    output eye_t       eye,
    input  logic       q_full,
    output logic       push,
    output job_t       job
);

    fix_t eye_reg [3];

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                eye_reg[i] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EYE_X: eye_reg[0] <= cfg_data;
                CFG_EYE_Y: eye_reg[1] <= cfg_data;
                CFG_EYE_Z: eye_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            eye[i] = eye_reg[i];
        job.d[0]  = vec_t'(in_data.target_x) - vec_t'(eye_reg[0]);
        job.d[1]  = vec_t'(in_data.target_y) - vec_t'(eye_reg[1]);
        job.d[2]  = vec_t'(in_data.target_z) - vec_t'(eye_reg[2]);
        job.up[0] = in_data.up_x;
        job.up[1] = in_data.up_y;
        job.up[2] = in_data.up_z;
    end

endmodule

### rtl/lav_queue.sv
// Short job queue between the front end and the compute back end.
module lav_queue import lav_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t             mem_reg [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;

    assign full    = (count_reg == QCW'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH)) else $error("queue count out of range");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

### rtl/lav_norm.sv
// Vector normalization unit: scaling, sum of squares, iterative square root and divider.
module lav_norm import lav_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  norm_req_t req,
    output norm_rsp_t rsp
);

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_SQRT  = 6'b001000,
        N_DSET  = 6'b010000,
        N_DIV   = 6'b100000
    } nstate_t;

    nstate_t          state_reg;
    logic [63:0]      m_reg [3];
    logic             neg_reg [3];
    logic [1:0]       idx_reg;
    logic [ITW-1:0]   it_reg;
    logic [59:0]      prod_reg;
    logic [63:0]      sum_reg;
    logic [63:0]      x_reg;
    logic [63:0]      r_reg;
    logic [63:0]      bit_reg;
    logic [31:0]      len_reg;
    logic [63:0]      num_reg;
    logic [32:0]      rem_reg;
    logic [QW-1:0]    q_reg;
    vec_t             u_reg [3];
    logic             ok_reg;
    logic             done_reg;

    logic [63:0]      mx;
    logic [63:0]      m_sel;
    logic [29:0]      sq_in;
    logic [63:0]      trial;
    logic             sq_ge;
    logic [63:0]      r_nx;
    logic [63:0]      ntmp;
    logic [63:0]      ntmp_hi;
    logic [32:0]      rem2;
    logic             d_ge;
    logic [32:0]      rem_nx;
    logic [QW-1:0]    q_nx;
    logic             all_zero;

    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx)
            mx = m_reg[1];
        if (m_reg[2] > mx)
            mx = m_reg[2];

        unique case (idx_reg)
            2'd0:    m_sel = m_reg[0];
            2'd1:    m_sel = m_reg[1];
            2'd2:    m_sel = m_reg[2];
            default: m_sel = '0;
        endcase
        sq_in = m_sel[29:0];

        trial = r_reg + bit_reg;
        sq_ge = (x_reg >= trial);
        r_nx  = sq_ge ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);

        ntmp    = (m_sel << FRAC_BITS) + {33'd0, len_reg[31:1]};
        ntmp_hi = ntmp >> QW;

        rem2   = {rem_reg[31:0], num_reg[QW-1]};
        d_ge   = (rem2 >= {1'b0, len_reg});
        rem_nx = d_ge ? (rem2 - {1'b0, len_reg}) : rem2;
        q_nx   = {q_reg[QW-2:0], d_ge};

        all_zero = (req.vec[0] == '0) && (req.vec[1] == '0) && (req.vec[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            idx_reg   <= '0;
            it_reg    <= '0;
            prod_reg  <= '0;
            sum_reg   <= '0;
            x_reg     <= '0;
            r_reg     <= '0;
            bit_reg   <= '0;
            len_reg   <= '0;
            num_reg   <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i]   <= '0;
                neg_reg[i] <= 1'b0;
                u_reg[i]   <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE:
                begin
                    if (req.start)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i]   <= mag64(req.vec[i]);
                            neg_reg[i] <= req.vec[i][63];
                        end
                        if (all_zero)
                        begin
                            for (int i = 0; i < 3; i++)
                                u_reg[i] <= '0;
                            ok_reg   <= 1'b0;
                            done_reg <= 1'b1;
                        end
                        else
                            state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (mx >= (64'd1 << 38))
                    begin
                        for (int i = 0; i < 3; i++)
                            m_reg[i] <= m_reg[i] >> 8;
                    end
                    else if (mx >= (64'd1 << 30))
                    begin
                        for (int i = 0; i < 3; i++)
                            m_reg[i] <= m_reg[i] >> 1;
                    end
                    else if (mx < (64'd1 << 21))
                    begin
                        for (int i = 0; i < 3; i++)
                            m_reg[i] <= m_reg[i] << 8;
                    end
                    else if (mx < (64'd1 << 29))
                    begin
                        for (int i = 0; i < 3; i++)
                            m_reg[i] <= m_reg[i] << 1;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        prod_reg  <= '0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    sum_reg  <= sum_reg + {4'd0, prod_reg};
                    prod_reg <= sq_in * sq_in;
                    if (idx_reg == 2'd3)
                    begin
                        x_reg     <= sum_reg + {4'd0, prod_reg};
                        r_reg     <= '0;
                        bit_reg   <= 64'd1 << 62;
                        state_reg <= N_SQRT;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                N_SQRT:
                begin
                    if (sq_ge)
                        x_reg <= x_reg - trial;
                    r_reg   <= r_nx;
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == 64'd1)
                    begin
                        len_reg   <= r_nx[31:0];
                        idx_reg   <= '0;
                        state_reg <= N_DSET;
                    end
                end
                N_DSET:
                begin
                    num_reg   <= ntmp;
                    rem_reg   <= ntmp_hi[32:0];
                    q_reg     <= '0;
                    it_reg    <= '0;
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    rem_reg <= rem_nx;
                    q_reg   <= q_nx;
                    num_reg <= num_reg << 1;
                    if (it_reg == ITW'(QW - 1))
                    begin
                        u_reg[idx_reg] <= neg_reg[idx_reg] ? -vec_t'(q_nx) : vec_t'(q_nx);
                        if (idx_reg == 2'd2)
                        begin
                            ok_reg    <= 1'b1;
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= N_DSET;
                        end
                    end
                    else
                        it_reg <= it_reg + 1'b1;
                end
                default:
                    state_reg <= N_IDLE;
            endcase
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.ok   = ok_reg;
        for (int i = 0; i < 3; i++)
            rsp.u[i] = u_reg[i];
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == N_IDLE) else $error("normalize started while busy");
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == N_DSET |-> len_reg >= (32'd1 << 29))
        else $error("square root below scaled range");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == N_DIV |-> rem_reg < {1'b0, len_reg})
        else $error("divider remainder out of range");
`endif

endmodule

### rtl/lav_back.sv
// Back end: sequencer with a shared multiplier for cross and dot products, and row output buffer.
module lav_back import lav_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    output logic      pop,
    input  job_t      job,
    input  eye_t      eye,
    output norm_req_t nreq,
    input  norm_rsp_t nrsp,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    typedef enum logic [8:0] {
        B_IDLE = 9'b000000001,
        B_NFS  = 9'b000000010,
        B_NFW  = 9'b000000100,
        B_MUL  = 9'b000001000,
        B_ACC  = 9'b000010000,
        B_STR  = 9'b000100000,
        B_NRS  = 9'b001000000,
        B_NRW  = 9'b010000000,
        B_DONE = 9'b100000000
    } bstate_t;

    typedef enum logic [2:0] {
        PH_CROSS = 3'b001,
        PH_UP    = 3'b010,
        PH_DOT   = 3'b100
    } phase_t;

    bstate_t     state_reg;
    phase_t      phase_reg;
    logic [1:0]  comp_reg;
    logic [1:0]  term_reg;
    vec_t        d_reg  [3];
    fix_t        up_reg [3];
    vec_t        f_reg  [3];
    vec_t        r_reg  [3];
    vec_t        u_reg  [3];
    acc_t        c_reg  [3];
    fix_t        t_reg  [3];
    logic        okf_reg;
    logic        okr_reg;
    acc_t        prod_reg;
    acc_t        acc_reg;

    fix_t        e_r_reg  [3];
    fix_t        e_u_reg  [3];
    fix_t        e_nf_reg [3];
    fix_t        e_t_reg  [3];
    logic        e_deg_reg;
    logic        e_valid_reg;
    logic [1:0]  e_row_reg;

    logic [1:0]          a_idx;
    logic [1:0]          b_idx;
    logic [1:0]          xi;
    logic [1:0]          yi;
    vec_t                opa;
    vec_t                opb;
    logic signed [65:0]  mul_full;
    logic                term_sub;
    logic                term_last;
    acc_t                acc_nx;
    acc_t                rnd;
    vec_t                nf [3];

    assign pop = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        a_idx = next3(comp_reg);
        b_idx = next3(a_idx);
        xi    = (term_reg == 2'd0) ? a_idx : b_idx;
        yi    = (term_reg == 2'd0) ? b_idx : a_idx;
        opa   = '0;
        opb   = '0;
        unique case (phase_reg)
            PH_CROSS:
            begin
                opa = f_reg[xi];
                opb = vec_t'(up_reg[yi]);
            end
            PH_UP:
            begin
                opa = r_reg[xi];
                opb = f_reg[yi];
            end
            PH_DOT:
            begin
                unique case (comp_reg)
                    2'd0:    opa = r_reg[term_reg];
                    2'd1:    opa = u_reg[term_reg];
                    default: opa = f_reg[term_reg];
                endcase
                opb = vec_t'(eye[term_reg]);
            end
            default: ;
        endcase
        mul_full  = opa * opb;
        term_sub  = (phase_reg != PH_DOT) && (term_reg == 2'd1);
        term_last = (phase_reg == PH_DOT) ? (term_reg == 2'd2) : (term_reg == 2'd1);
        acc_nx    = term_sub ? (acc_reg - prod_reg) : (acc_reg + prod_reg);
        rnd       = shift_round(acc_reg);
        for (int i = 0; i < 3; i++)
            nf[i] = -f_reg[i];

        nreq.start = (state_reg == B_NFS) || (state_reg == B_NRS);
        for (int i = 0; i < 3; i++)
            nreq.vec[i] = (state_reg == B_NRS) ? c_reg[i] : acc_t'(d_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            phase_reg   <= PH_CROSS;
            comp_reg    <= '0;
            term_reg    <= '0;
            okf_reg     <= 1'b0;
            okr_reg     <= 1'b0;
            prod_reg    <= '0;
            acc_reg     <= '0;
            e_deg_reg   <= 1'b0;
            e_valid_reg <= 1'b0;
            e_row_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]    <= '0;
                up_reg[i]   <= '0;
                f_reg[i]    <= '0;
                r_reg[i]    <= '0;
                u_reg[i]    <= '0;
                c_reg[i]    <= '0;
                t_reg[i]    <= '0;
                e_r_reg[i]  <= '0;
                e_u_reg[i]  <= '0;
                e_nf_reg[i] <= '0;
                e_t_reg[i]  <= '0;
            end
        end
        else
        begin
            if (e_valid_reg && !out_stall)
            begin
                if (e_row_reg == 2'd3)
                    e_valid_reg <= 1'b0;
                else
                    e_row_reg <= e_row_reg + 2'd1;
            end

            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            d_reg[i]  <= job.d[i];
                            up_reg[i] <= job.up[i];
                        end
                        state_reg <= B_NFS;
                    end
                end
                B_NFS:
                    state_reg <= B_NFW;
                B_NFW:
                begin
                    if (nrsp.done)
                    begin
                        for (int i = 0; i < 3; i++)
                            f_reg[i] <= nrsp.u[i];
                        okf_reg   <= nrsp.ok;
                        phase_reg <= PH_CROSS;
                        comp_reg  <= '0;
                        term_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    prod_reg  <= mul_full[63:0];
                    state_reg <= B_ACC;
                end
                B_ACC:
                begin
                    acc_reg <= acc_nx;
                    if (term_last)
                        state_reg <= B_STR;
                    else
                    begin
                        term_reg  <= term_reg + 2'd1;
                        state_reg <= B_MUL;
                    end
                end
                B_STR:
                begin
                    unique case (phase_reg)
                        PH_CROSS: c_reg[comp_reg] <= acc_reg;
                        PH_UP:    u_reg[comp_reg] <= rnd[32:0];
                        PH_DOT:   t_reg[comp_reg] <= (comp_reg == 2'd2) ? sat32(rnd)
                                                                          : sat32(-rnd);
                        default:  ;
                    endcase
                    acc_reg  <= '0;
                    term_reg <= '0;
                    if (comp_reg == 2'd2)
                    begin
                        comp_reg <= '0;
                        unique case (phase_reg)
                            PH_CROSS: state_reg <= B_NRS;
                            PH_UP:
                            begin
                                phase_reg <= PH_DOT;
                                state_reg <= B_MUL;
                            end
                            default:  state_reg <= B_DONE;
                        endcase
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= B_MUL;
                    end
                end
                B_NRS:
                    state_reg <= B_NRW;
                B_NRW:
                begin
                    if (nrsp.done)
                    begin
                        for (int i = 0; i < 3; i++)
                            r_reg[i] <= nrsp.u[i];
                        okr_reg   <= nrsp.ok;
                        phase_reg <= PH_UP;
                        comp_reg  <= '0;
                        term_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= B_MUL;
                    end
                end
                B_DONE:
                begin
                    if (!e_valid_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            e_r_reg[i]  <= r_reg[i][31:0];
                            e_u_reg[i]  <= u_reg[i][31:0];
                            e_nf_reg[i] <= nf[i][31:0];
                            e_t_reg[i]  <= t_reg[i];
                        end
                        e_deg_reg   <= !(okf_reg && okr_reg);
                        e_row_reg   <= '0;
                        e_valid_reg <= 1'b1;
                        state_reg   <= B_IDLE;
                    end
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    assign out_valid = e_valid_reg;

    always_comb
    begin
        out_data.row_index  = e_row_reg;
        out_data.degenerate = e_deg_reg;
        out_data.last       = (e_row_reg == 2'd3);
        unique case (e_row_reg)
            2'd0:
            begin
                out_data.elem0 = e_r_reg[0];
                out_data.elem1 = e_u_reg[0];
                out_data.elem2 = e_nf_reg[0];
                out_data.elem3 = '0;
            end
            2'd1:
            begin
                out_data.elem0 = e_r_reg[1];
                out_data.elem1 = e_u_reg[1];
                out_data.elem2 = e_nf_reg[1];
                out_data.elem3 = '0;
            end
            2'd2:
            begin
                out_data.elem0 = e_r_reg[2];
                out_data.elem1 = e_u_reg[2];
                out_data.elem2 = e_nf_reg[2];
                out_data.elem3 = '0;
            end
            default:
            begin
                out_data.elem0 = e_t_reg[0];
                out_data.elem1 = e_t_reg[1];
                out_data.elem2 = e_t_reg[2];
                out_data.elem3 = fix_t'(ONE_FIX);
            end
        endcase
    end

`ifndef SYNTHESIS
    a_norm_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        nrsp.done |-> (state_reg == B_NFW || state_reg == B_NRW))
        else $error("normalize result arrived while not waiting");
    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && e_row_reg != 2'd3
        |=> out_valid && e_row_reg == $past(e_row_reg) + 2'd1)
        else $error("row sequence broken");
    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DONE && !e_valid_reg |=> e_valid_reg && e_row_reg == 2'd0)
        else $error("finished matrix not loaded into output buffer");
`endif

endmodule

### rtl/look_at_view_matrix_top.sv
// Top level of the look-at view matrix block.
//
// Usage: the eye position is written through the configuration channel
// (cfg_valid, cfg_ready, cfg_index 0 to 2 for x, y, z, cfg_data) while the
// block is idle. Each input transfer carries a target point and a world up
// direction in signed Q16.16; the block answers with four output transfers,
// rows 0 to 3 of the view matrix, with last set on row 3.
// A two-entry queue sits behind the input, so the input is stalled only when
// the queue is full. The time the back end spends on an item is set mostly by
// the shared normalization unit, which runs twice per item: up to ten scaling
// steps, four for the sum of squares, 32 square root steps and a bit-serial
// division for each component. A zero-length vector skips these steps and
// gives a zero result. The back end takes the next item from the queue only
// once the current matrix is in the output buffer. The four rows follow on
// consecutive cycles while the receiver does not stall.
// Finished rows wait in an output buffer while the next item is computed; when
// the receiver stalls, the current row holds, and the buffer takes the next
// matrix once row 3 has transferred.
// Reset clears the eye position to zero and empties the queue and buffer.
module look_at_view_matrix_top import lav_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  fix_t       cfg_data
);

    eye_t      eye;
    logic      q_full;
    logic      q_empty;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      pop_job;
    norm_req_t nreq;
    norm_rsp_t nrsp;

    lav_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eye       (eye),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    lav_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    lav_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (nreq),
        .rsp   (nrsp)
    );

    lav_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop       (pop),
        .job       (pop_job),
        .eye       (eye),
        .nreq      (nreq),
        .nrsp      (nrsp),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### verif/look_at_view_matrix_checker.sv
// Checker that predicts the look-at view matrix rows and compares them with the block's output.
`timescale 1ns / 100ps
module look_at_view_matrix_checker import lav_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  fix_t      cfg_data,
    output int        fail_count,
    output int        rows_pending,
    output int        rows_seen
);

    typedef logic signed [63:0] wide_t;

    wide_t eye_pos [3];
    out_item_t row_queue [$];

    function automatic logic [63:0] magnitude(input wide_t v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic unit_vector(input wide_t v [3], output wide_t u [3]);
        logic [63:0] m [3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = magnitude(v[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            for (int i = 0; i < 3; i++)
                u[i] = 0;
            return 1'b0;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++)
            sum = sum + m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -wide_t'(q) : wide_t'(q);
        end
        return 1'b1;
    endfunction

    function automatic wide_t round_shift(input wide_t p);
        logic [63:0] m;
        m = (magnitude(p) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return p < 0 ? -wide_t'(m) : wide_t'(m);
    endfunction

    function automatic wide_t clamp32(input wide_t v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    task automatic predict_rows(input in_item_t it);
        wide_t d [3];
        wide_t upv [3];
        wide_t f [3];
        wide_t c [3];
        wide_t r [3];
        wide_t u [3];
        wide_t t [3];
        logic okf;
        logic okr;
        out_item_t row;
        d[0] = wide_t'(it.target_x) - eye_pos[0];
        d[1] = wide_t'(it.target_y) - eye_pos[1];
        d[2] = wide_t'(it.target_z) - eye_pos[2];
        upv[0] = wide_t'(it.up_x);
        upv[1] = wide_t'(it.up_y);
        upv[2] = wide_t'(it.up_z);
        okf = unit_vector(d, f);
        c[0] = f[1] * upv[2] - f[2] * upv[1];
        c[1] = f[2] * upv[0] - f[0] * upv[2];
        c[2] = f[0] * upv[1] - f[1] * upv[0];
        okr = unit_vector(c, r);
        u[0] = round_shift(r[1] * f[2] - r[2] * f[1]);
        u[1] = round_shift(r[2] * f[0] - r[0] * f[2]);
        u[2] = round_shift(r[0] * f[1] - r[1] * f[0]);
        t[0] = clamp32(-round_shift(r[0] * eye_pos[0] + r[1] * eye_pos[1] + r[2] * eye_pos[2]));
        t[1] = clamp32(-round_shift(u[0] * eye_pos[0] + u[1] * eye_pos[1] + u[2] * eye_pos[2]));
        t[2] = clamp32(round_shift(f[0] * eye_pos[0] + f[1] * eye_pos[1] + f[2] * eye_pos[2]));
        for (int i = 0; i < 4; i++)
        begin
            row.row_index = 2'(i);
            if (i < 3)
            begin
                row.elem0 = fix_t'(r[i]);
                row.elem1 = fix_t'(u[i]);
                row.elem2 = fix_t'(-f[i]);
                row.elem3 = '0;
            end
            else
            begin
                row.elem0 = fix_t'(t[0]);
                row.elem1 = fix_t'(t[1]);
                row.elem2 = fix_t'(t[2]);
                row.elem3 = ONE_FIX;
            end
            row.degenerate = !(okf && okr);
            row.last = (i == 3);
            row_queue.push_back(row);
        end
    endtask

    task automatic compare_row(input out_item_t got);
        out_item_t want;
        if (row_queue.size() == 0)
        begin
            $error("row transfer with no expected row");
            fail_count++;
            return;
        end
        want = row_queue.pop_front();
        if (got.row_index !== want.row_index)
        begin
            $error("row_index expected %0d actual %0d", want.row_index, got.row_index);
            fail_count++;
        end
        if (got.elem0 !== want.elem0)
        begin
            $error("elem0 expected %0d actual %0d", want.elem0, got.elem0);
            fail_count++;
        end
        if (got.elem1 !== want.elem1)
        begin
            $error("elem1 expected %0d actual %0d", want.elem1, got.elem1);
            fail_count++;
        end
        if (got.elem2 !== want.elem2)
        begin
            $error("elem2 expected %0d actual %0d", want.elem2, got.elem2);
            fail_count++;
        end
        if (got.elem3 !== want.elem3)
        begin
            $error("elem3 expected %0d actual %0d", want.elem3, got.elem3);
            fail_count++;
        end
        if (got.degenerate !== want.degenerate)
        begin
            $error("degenerate expected %0d actual %0d", want.degenerate, got.degenerate);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last expected %0d actual %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        rows_pending = 0;
        rows_seen = 0;
        for (int i = 0; i < 3; i++)
            eye_pos[i] = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_EYE_X: eye_pos[0] = wide_t'(cfg_data);
                    CFG_EYE_Y: eye_pos[1] = wide_t'(cfg_data);
                    CFG_EYE_Z: eye_pos[2] = wide_t'(cfg_data);
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_rows(in_data);
            if (out_valid && !out_stall)
            begin
                compare_row(out_data);
                rows_seen++;
            end
            rows_pending = row_queue.size();
        end
    end

endmodule

### verif/look_at_view_matrix_top_test.sv
// Testbench top that drives the look-at view matrix block and reports the verdict.
`timescale 1ns / 100ps
module look_at_view_matrix_top_test;
    import lav_pkg::*;

    localparam int RANDOM_ITEMS = 190;
    localparam int SETTLE_CYCLES = 600;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    fix_t       cfg_data;
    int         fail_count;
    int         rows_pending;
    int         rows_seen;
    int         items_sent;
    logic       calm;

    look_at_view_matrix_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    look_at_view_matrix_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .rows_pending(rows_pending), .rows_seen(rows_seen)
    );

    initial
        clk = 1'b0;
    always #10 clk = ~clk;

    // The receiver stalls in random bursts until the final part of the run.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic fix_t edge_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return ONE_FIX;
            4: return -ONE_FIX;
            default: return fix_t'($urandom);
        endcase
    endfunction

    function automatic fix_t rand_coord();
        case ($urandom_range(0, 9))
            0: return edge_value();
            1, 2: return fix_t'($urandom);
            default: return fix_t'($urandom_range(0, 32'h00140000)) - fix_t'(32'h000a0000);
        endcase
    endfunction

    task automatic write_eye(input cfg_index_t idx, input fix_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_item(input in_item_t it);
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (rows_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_pair(input fix_t tx, ty, tz, ux, uy, uz);
        in_item_t it;
        it = '{tx, ty, tz, ux, uy, uz};
        send_item(it);
    endtask

    initial
    begin
        in_item_t it;
        calm = 1'b0;
        items_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_EYE_X;
        cfg_data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed items with the eye at the origin.
        send_pair(0, 0, -ONE_FIX, 0, ONE_FIX, 0);
        send_pair(0, 0, 0, 0, ONE_FIX, 0);
        send_pair(0, 0, ONE_FIX, 0, 0, ONE_FIX);
        send_pair(ONE_FIX, 0, 0, 0, 0, 0);
        send_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
        send_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_pair(1, 0, 0, 0, 1, 0);
        send_pair(32'h80000000, 32'h7fffffff, 1, 32'h7fffffff, 32'h80000000, 32'hffffffff);
        send_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 32'hffffffff);
        drain();

        // Extreme eye positions to drive translation into saturation.
        write_eye(CFG_EYE_X, 32'h7fffffff);
        write_eye(CFG_EYE_Y, 32'h80000000);
        write_eye(CFG_EYE_Z, 32'h7fffffff);
        send_pair(32'h80000000, 32'h7fffffff, 32'h80000000, 0, ONE_FIX, 0);
        send_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, ONE_FIX, 0, ONE_FIX);
        send_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, ONE_FIX, 0);
        send_pair(0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        drain();
        write_eye(CFG_EYE_X, 32'h80000000);
        write_eye(CFG_EYE_Y, 32'h7fffffff);
        write_eye(CFG_EYE_Z, 32'h80000000);
        send_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, ONE_FIX);
        send_pair(32'h80000000, 32'h7fffffff, 32'h80000000, 0, ONE_FIX, 0);
        send_pair(0, 0, 0, ONE_FIX, ONE_FIX, 0);
        drain();

        // Random phases, each with its own eye position.
        for (int ph = 0; ph < 5; ph++)
        begin
            write_eye(CFG_EYE_X, rand_coord());
            write_eye(CFG_EYE_Y, rand_coord());
            write_eye(CFG_EYE_Z, rand_coord());
            if (ph == 4)
                calm = 1'b1;
            for (int k = 0; k < RANDOM_ITEMS / 5; k++)
            begin
                it.target_x = rand_coord();
                it.target_y = rand_coord();
                it.target_z = rand_coord();
                it.up_x = rand_coord();
                it.up_y = rand_coord();
                it.up_z = rand_coord();
                // Now and then up is set equal to the target point, or its x component is cleared.
                if ($urandom_range(0, 11) == 0)
                begin
                    it.up_x = it.target_x;
                    it.up_y = it.target_y;
                    it.up_z = it.target_z;
                end
                else if ($urandom_range(0, 15) == 0)
                    it.up_x = '0;
                send_item(it);
            end
            drain();
        end

        $display("Sent %0d items and checked %0d matrix rows over several eye positions,",
            items_sent, rows_seen);
        $display("including extreme coordinates, degenerate inputs and saturated translations.");
        if (fail_count == 0)
            $display("look_at_view_matrix_top test passed");
        else
            $display("look_at_view_matrix_top test failed");
        $finish;
    end

    initial
    begin
        #(400 * 1000 * 20);
        $display("look_at_view_matrix_top test failed");
        $finish;
    end

endmodule
